@@ hdl/plc_pkg.sv @@
// Shared constants, types and state encodings for the polyline crossing finder.
`default_nettype none
package plc_pkg;

  localparam int COORD_W    = 48;
  localparam int FRAC_W     = 16;
  localparam int TOL_W      = 16;
  localparam int PLIM_W     = 32;
  localparam int HIT_CAP    = 31;
  localparam int CNT_W      = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COORD_W;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int VAL_W      = 2 * DIFF_W + 1;
  localparam int DET_W      = VAL_W + 1;
  localparam int NUM_W      = DIFF_W + VAL_W;
  localparam int QUO_W      = COORD_W + 3;
  localparam int SUM_W      = QUO_W + 2;
  localparam int NEAR_W     = SUM_W + 1;
  localparam int BIT_W      = 6;

  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic signed [COORD_W-1:0] LINE_END_X_RST = COORD_W'(1) << FRAC_W;
  localparam logic [TOL_W-1:0]          TOL_RST  = TOL_W'(66);
  localparam logic [PLIM_W-1:0]         PLIM_RST = PLIM_W'(429497);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINE_START_X   = 3'd0,
    REG_LINE_START_Y   = 3'd1,
    REG_LINE_END_X     = 3'd2,
    REG_LINE_END_Y     = 3'd3,
    REG_EDGE_TOLERANCE = 3'd4,
    REG_PARALLEL_LIMIT = 3'd5
  } plc_reg_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] sx;
    logic signed [COORD_W-1:0] sy;
    logic signed [COORD_W-1:0] ex;
    logic signed [COORD_W-1:0] ey;
    logic [TOL_W-1:0]          tol;
    logic [PLIM_W-1:0]         plim;
  } plc_cfg_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SHIFT,
    CELL_SORT
  } plc_cell_op_e;

  typedef struct packed {
    plc_cell_op_e     op;
    logic             phase;
    logic             sortx;
    logic [CNT_W-1:0] count;
  } plc_cell_ctrl_t;

  typedef struct packed {
    logic                      done;
    logic                      hit;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } plc_hit_t;

  typedef enum logic [2:0] {
    MOP_AX1,
    MOP_BY1,
    MOP_AX2,
    MOP_BY2,
    MOP_QX,
    MOP_QY
  } plc_mop_e;

  typedef enum logic [2:0] {
    E_IDLE,
    E_MUL,
    E_CHK,
    E_DIVI,
    E_DIV,
    E_FIN,
    E_DONE
  } plc_edge_state_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EDGE,
    S_ALIGN,
    S_SORT,
    S_OUT
  } plc_state_e;

endpackage
`default_nettype wire

@@ hdl/plc_edge.sv @@
// Edge/line intersection unit: serial shift-add multiplier and restoring divider.
`default_nettype none
module plc_edge (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  plc_pkg::plc_cfg_t                  cfg_i,
  input  logic signed [plc_pkg::COORD_W-1:0] x1_i,
  input  logic signed [plc_pkg::COORD_W-1:0] y1_i,
  input  logic signed [plc_pkg::COORD_W-1:0] x2_i,
  input  logic signed [plc_pkg::COORD_W-1:0] y2_i,
  output plc_pkg::plc_hit_t                  hit_o
);
  import plc_pkg::*;

  plc_edge_state_e state_q, state_d;
  plc_mop_e        mop_q, mop_d;
  logic [BIT_W-1:0] bit_q, bit_d;

  logic signed [COORD_W-1:0] x1_q, y1_q, x2_q, y2_q;
  logic signed [DIFF_W-1:0]  a_q, b_q, dx1_q, dy1_q, dx2_q, dy2_q, ddx_q, ddy_q;
  logic [TOL_W-1:0]          tol_q;
  logic [PLIM_W-1:0]         plim_q;
  logic signed [NUM_W-1:0]   acc_q, mcand_q;
  logic [DIFF_W-1:0]         mplier_q;
  logic signed [VAL_W-1:0]   v1_q;
  logic [DET_W-1:0]          dabs_q, rem_q;
  logic                      dneg_q, qneg_q, ovf_q, hit_q;
  logic [QUO_W-1:0]          num_q, quo_q;
  logic signed [QUO_W:0]     qx_q, qy_q;
  logic signed [COORD_W-1:0] hx_q, hy_q;

  logic signed [DIFF_W-1:0] a_c, b_c, dx1_c;
  logic                     mul_last, div_last, tfit, det_rej, accept;
  logic signed [NUM_W-1:0]  acc_add;
  logic [DET_W-1:0]         trial, det_abs, rem0;
  logic [QUO_W-1:0]         quo_nx;
  logic signed [QUO_W:0]    q_signed;
  logic signed [DET_W-1:0]  det;
  logic [NUM_W-1:0]         nabs;
  logic signed [SUM_W-1:0]  px, py, mnx, mxx, mny, mxy;
  logic                     inx, iny;

  function automatic logic near_f(input logic signed [SUM_W-1:0] v,
                                  input logic signed [SUM_W-1:0] e,
                                  input logic [TOL_W-1:0] t);
    logic signed [NEAR_W-1:0] d;
    logic [NEAR_W-1:0]        m;
    d = NEAR_W'(v) - NEAR_W'(e);
    m = d[NEAR_W-1] ? NEAR_W'(-d) : NEAR_W'(d);
    return m < NEAR_W'(t);
  endfunction

  function automatic logic signed [COORD_W-1:0] sat_f(input logic signed [SUM_W-1:0] v);
    if (v > SUM_W'(COORD_MAX)) return COORD_MAX;
    else if (v < SUM_W'(COORD_MIN)) return COORD_MIN;
    else return v[COORD_W-1:0];
  endfunction

  assign a_c   = DIFF_W'(cfg_i.ey) - DIFF_W'(cfg_i.sy);
  assign b_c   = DIFF_W'(cfg_i.sx) - DIFF_W'(cfg_i.ex);
  assign dx1_c = DIFF_W'(x1_i) - DIFF_W'(cfg_i.sx);

  // sign bit of the multiplier carries negative weight
  assign mul_last = (bit_q == BIT_W'(DIFF_W - 1));
  assign acc_add  = mplier_q[0] ? (mul_last ? acc_q - mcand_q : acc_q + mcand_q) : acc_q;

  assign div_last = (bit_q == BIT_W'(QUO_W - 1));
  assign trial    = {rem_q[DET_W-2:0], num_q[QUO_W-1]};
  assign tfit     = (trial >= dabs_q);
  assign quo_nx   = {quo_q[QUO_W-2:0], tfit};
  assign q_signed = qneg_q ? -$signed({1'b0, quo_nx}) : $signed({1'b0, quo_nx});

  assign det     = DET_W'(v1_q) - DET_W'($signed(acc_q[VAL_W-1:0]));
  assign det_abs = det[DET_W-1] ? DET_W'(-det) : DET_W'(det);
  assign det_rej = (det == '0) || (det_abs < DET_W'(plim_q));
  assign nabs    = acc_q[NUM_W-1] ? NUM_W'(-acc_q) : NUM_W'(acc_q);
  assign rem0    = DET_W'(nabs[NUM_W-1:QUO_W]);

  assign px  = SUM_W'(x1_q) + SUM_W'(qx_q);
  assign py  = SUM_W'(y1_q) + SUM_W'(qy_q);
  assign mnx = (x1_q <= x2_q) ? SUM_W'(x1_q) : SUM_W'(x2_q);
  assign mxx = (x1_q <= x2_q) ? SUM_W'(x2_q) : SUM_W'(x1_q);
  assign mny = (y1_q <= y2_q) ? SUM_W'(y1_q) : SUM_W'(y2_q);
  assign mxy = (y1_q <= y2_q) ? SUM_W'(y2_q) : SUM_W'(y1_q);
  assign inx = (px >= mnx) && (px <= mxx);
  assign iny = (py >= mny) && (py <= mxy);
  assign accept = !ovf_q && ((inx && iny) ||
                  (iny && (near_f(px, mnx, tol_q) || near_f(px, mxx, tol_q))) ||
                  (inx && (near_f(py, mny, tol_q) || near_f(py, mxy, tol_q))));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      E_IDLE: if (start_i) state_d = E_MUL;
      E_MUL: begin
        if (mul_last) begin
          unique case (mop_q)
            MOP_BY2:        state_d = E_CHK;
            MOP_QX, MOP_QY: state_d = E_DIVI;
            default:        state_d = E_MUL;
          endcase
        end
      end
      E_CHK:  state_d = det_rej ? E_DONE : E_MUL;
      E_DIVI: state_d = E_DIV;
      E_DIV: begin
        if (div_last) state_d = (mop_q == MOP_QX) ? E_MUL : E_FIN;
      end
      E_FIN:  state_d = E_DONE;
      E_DONE: state_d = E_IDLE;
      default: state_d = E_IDLE;
    endcase
  end

  // sequencing counters
  always_comb begin
    mop_d = mop_q;
    bit_d = '0;
    unique case (state_q)
      E_IDLE: if (start_i) mop_d = MOP_AX1;
      E_MUL: begin
        bit_d = mul_last ? '0 : bit_q + BIT_W'(1);
        if (mul_last) begin
          unique case (mop_q)
            MOP_AX1: mop_d = MOP_BY1;
            MOP_BY1: mop_d = MOP_AX2;
            MOP_AX2: mop_d = MOP_BY2;
            default: mop_d = mop_q;
          endcase
        end
      end
      E_CHK: mop_d = MOP_QX;
      E_DIV: begin
        bit_d = div_last ? '0 : bit_q + BIT_W'(1);
        if (div_last && mop_q == MOP_QX) mop_d = MOP_QY;
      end
      default: mop_d = mop_q;
    endcase
  end

  // outputs
  always_comb begin
    hit_o.done = (state_q == E_DONE);
    hit_o.hit  = hit_q;
    hit_o.x    = hx_q;
    hit_o.y    = hy_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= E_IDLE;
      mop_q   <= MOP_AX1;
      bit_q   <= '0;
    end else begin
      state_q <= state_d;
      mop_q   <= mop_d;
      bit_q   <= bit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      E_IDLE: begin
        if (start_i) begin
          x1_q     <= x1_i;
          y1_q     <= y1_i;
          x2_q     <= x2_i;
          y2_q     <= y2_i;
          a_q      <= a_c;
          b_q      <= b_c;
          dx1_q    <= dx1_c;
          dy1_q    <= DIFF_W'(y1_i) - DIFF_W'(cfg_i.sy);
          dx2_q    <= DIFF_W'(x2_i) - DIFF_W'(cfg_i.sx);
          dy2_q    <= DIFF_W'(y2_i) - DIFF_W'(cfg_i.sy);
          ddx_q    <= DIFF_W'(x2_i) - DIFF_W'(x1_i);
          ddy_q    <= DIFF_W'(y2_i) - DIFF_W'(y1_i);
          tol_q    <= cfg_i.tol;
          plim_q   <= cfg_i.plim;
          acc_q    <= '0;
          mcand_q  <= NUM_W'(dx1_c);
          mplier_q <= a_c;
          ovf_q    <= 1'b0;
        end
      end
      E_MUL: begin
        acc_q    <= acc_add;
        mcand_q  <= mcand_q <<< 1;
        mplier_q <= mplier_q >> 1;
        if (mul_last) begin
          unique case (mop_q)
            MOP_AX1: begin
              mcand_q  <= NUM_W'(dy1_q);
              mplier_q <= b_q;
            end
            MOP_BY1: begin
              v1_q     <= acc_add[VAL_W-1:0];
              acc_q    <= '0;
              mcand_q  <= NUM_W'(dx2_q);
              mplier_q <= a_q;
            end
            MOP_AX2: begin
              mcand_q  <= NUM_W'(dy2_q);
              mplier_q <= b_q;
            end
            default: begin
            end
          endcase
        end
      end
      E_CHK: begin
        dabs_q   <= det_abs;
        dneg_q   <= det[DET_W-1];
        acc_q    <= '0;
        mcand_q  <= NUM_W'(v1_q);
        mplier_q <= ddx_q;
        hit_q    <= 1'b0;
      end
      E_DIVI: begin
        rem_q  <= rem0;
        num_q  <= nabs[QUO_W-1:0];
        qneg_q <= acc_q[NUM_W-1] ^ dneg_q;
        // a quotient this large lands far outside any edge box
        if (rem0 >= dabs_q) ovf_q <= 1'b1;
      end
      E_DIV: begin
        rem_q <= tfit ? trial - dabs_q : trial;
        num_q <= num_q << 1;
        quo_q <= quo_nx;
        if (div_last) begin
          if (mop_q == MOP_QX) begin
            qx_q     <= q_signed;
            acc_q    <= '0;
            mcand_q  <= NUM_W'(v1_q);
            mplier_q <= ddy_q;
          end else begin
            qy_q <= q_signed;
          end
        end
      end
      E_FIN: begin
        hit_q <= accept;
        hx_q  <= sat_f(px);
        hy_q  <= sat_f(py);
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

@@ hdl/plc_cell.sv @@
// One cell of the crossing chain: holds a point, shifts or compare-swaps with neighbours.
`default_nettype none
module plc_cell (
  input  logic                               clk_i,
  input  plc_pkg::plc_cell_ctrl_t            ctrl_i,
  input  logic [plc_pkg::CNT_W-1:0]          idx_i,
  input  logic signed [plc_pkg::COORD_W-1:0] up_x_i,
  input  logic signed [plc_pkg::COORD_W-1:0] up_y_i,
  input  logic signed [plc_pkg::COORD_W-1:0] dn_x_i,
  input  logic signed [plc_pkg::COORD_W-1:0] dn_y_i,
  input  logic                               swap_dn_i,
  output logic signed [plc_pkg::COORD_W-1:0] x_o,
  output logic signed [plc_pkg::COORD_W-1:0] y_o,
  output logic                               swap_o
);
  import plc_pkg::*;

  logic signed [COORD_W-1:0] x_q, y_q, key_self, key_up;
  logic                      pair_live;

  assign key_self  = ctrl_i.sortx ? x_q : y_q;
  assign key_up    = ctrl_i.sortx ? up_x_i : up_y_i;
  assign pair_live = ({1'b0, idx_i} + (CNT_W+1)'(1)) < {1'b0, ctrl_i.count};
  // strict compare keeps equal keys in arrival order
  assign swap_o = (ctrl_i.op == CELL_SORT) && (idx_i[0] == ctrl_i.phase) &&
                  pair_live && (key_self > key_up);

  assign x_o = x_q;
  assign y_o = y_q;

  always_ff @(posedge clk_i) begin
    unique case (ctrl_i.op)
      CELL_SHIFT: begin
        x_q <= up_x_i;
        y_q <= up_y_i;
      end
      CELL_SORT: begin
        if (swap_o) begin
          x_q <= up_x_i;
          y_q <= up_y_i;
        end else if (swap_dn_i) begin
          x_q <= dn_x_i;
          y_q <= dn_y_i;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

@@ hdl/polyline_line_crossings_sorted.sv @@
// Top level: configuration registers, run control and the sorting chain of cells.
// Vertices: the first vertex of a run is stored as the start of its first edge; every later
//   vertex runs an edge through the 49-step serial multiplier (six products) and the 51-step
//   divider (two quotients); an edge that counts as parallel stops after four products.
// Last vertex: the chain shifts to align the hits, then runs 31 odd-even sort passes,
//   then one result per cycle while the sink takes them.
// Reset: run state and counters clear, registers take their defaults; the point chain
//   is not cleared and needs no clearing pass.
`default_nettype none
module polyline_line_crossings_sorted (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [plc_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [plc_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [plc_pkg::COORD_W-1:0]   vertex_x_i,
  input  logic signed [plc_pkg::COORD_W-1:0]   vertex_y_i,
  input  logic                                 vertex_last_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [plc_pkg::COORD_W-1:0]   cross_x_o,
  output logic signed [plc_pkg::COORD_W-1:0]   cross_y_o,
  output logic                                 cross_valid_o,
  output logic [plc_pkg::CNT_W-1:0]            cross_count_o,
  output logic                                 run_last_o
);
  import plc_pkg::*;

  plc_cfg_t   cfg_q;
  plc_state_e state_q, state_d;

  logic [CNT_W-1:0]          count_q, remain_q, step_q;
  logic                      have_prev_q, last_q, sortx_q, empty_q;
  logic signed [COORD_W-1:0] prev_x_q, prev_y_q;

  logic           in_beat, out_beat, edge_start, append, finish, finish_now;
  logic [CNT_W-1:0] count_nx;
  plc_hit_t       hit;
  plc_cell_ctrl_t cctrl;

  logic signed [DIFF_W-1:0] ldx, ldy;
  logic [DIFF_W-1:0]        adx, ady;
  logic                     sortx_c;

  logic signed [COORD_W-1:0] chain_x [HIT_CAP];
  logic signed [COORD_W-1:0] chain_y [HIT_CAP];
  logic                      swap    [HIT_CAP];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sx   <= '0;
      cfg_q.sy   <= '0;
      cfg_q.ex   <= LINE_END_X_RST;
      cfg_q.ey   <= '0;
      cfg_q.tol  <= TOL_RST;
      cfg_q.plim <= PLIM_RST;
    end else if (cfg_we_i) begin
      unique case (plc_reg_e'(cfg_idx_i))
        REG_LINE_START_X:   cfg_q.sx   <= $signed(cfg_data_i);
        REG_LINE_START_Y:   cfg_q.sy   <= $signed(cfg_data_i);
        REG_LINE_END_X:     cfg_q.ex   <= $signed(cfg_data_i);
        REG_LINE_END_Y:     cfg_q.ey   <= $signed(cfg_data_i);
        REG_EDGE_TOLERANCE: cfg_q.tol  <= cfg_data_i[TOL_W-1:0];
        REG_PARALLEL_LIMIT: cfg_q.plim <= cfg_data_i[PLIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // sort on x when the line runs closer to horizontal
  assign ldx     = DIFF_W'(cfg_q.ex) - DIFF_W'(cfg_q.sx);
  assign ldy     = DIFF_W'(cfg_q.ey) - DIFF_W'(cfg_q.sy);
  assign adx     = ldx[DIFF_W-1] ? DIFF_W'(-ldx) : DIFF_W'(ldx);
  assign ady     = ldy[DIFF_W-1] ? DIFF_W'(-ldy) : DIFF_W'(ldy);
  assign sortx_c = adx > ady;

  assign in_beat    = in_valid_i && in_ready_o;
  assign out_beat   = out_valid_o && out_ready_i;
  assign edge_start = in_beat && have_prev_q;
  // drop crossings once the chain is full
  assign append     = (state_q == S_EDGE) && hit.done && hit.hit &&
                      (count_q < CNT_W'(HIT_CAP));
  assign count_nx   = count_q + CNT_W'(append);
  // run ends on a first-and-last vertex or when the last edge completes
  assign finish_now = in_beat && !have_prev_q && vertex_last_i;
  assign finish     = finish_now || ((state_q == S_EDGE) && hit.done && last_q);

  plc_edge u_edge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (edge_start),
    .cfg_i   (cfg_q),
    .x1_i    (prev_x_q),
    .y1_i    (prev_y_q),
    .x2_i    (vertex_x_i),
    .y2_i    (vertex_y_i),
    .hit_o   (hit)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_beat) begin
          if (have_prev_q)        state_d = S_EDGE;
          else if (vertex_last_i) state_d = S_OUT;
        end
      end
      S_EDGE: begin
        if (hit.done) begin
          if (!last_q)              state_d = S_IDLE;
          else if (count_nx == '0)  state_d = S_OUT;
          else                      state_d = S_ALIGN;
        end
      end
      S_ALIGN: if (step_q == '0) state_d = S_SORT;
      S_SORT:  if (step_q == '0) state_d = S_OUT;
      S_OUT:   if (out_beat && run_last_o) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // outputs and chain control
  always_comb begin
    in_ready_o  = (state_q == S_IDLE);
    out_valid_o = (state_q == S_OUT);
    cctrl.phase = step_q[0];
    cctrl.sortx = sortx_q;
    cctrl.count = count_q;
    unique case (state_q)
      S_EDGE:  cctrl.op = append ? CELL_SHIFT : CELL_HOLD;
      S_ALIGN: cctrl.op = (step_q != '0) ? CELL_SHIFT : CELL_HOLD;
      S_SORT:  cctrl.op = CELL_SORT;
      S_OUT:   cctrl.op = (out_beat && !run_last_o) ? CELL_SHIFT : CELL_HOLD;
      default: cctrl.op = CELL_HOLD;
    endcase
  end

  assign cross_x_o     = empty_q ? '0 : chain_x[0];
  assign cross_y_o     = empty_q ? '0 : chain_y[0];
  assign cross_valid_o = !empty_q;
  assign cross_count_o = count_q;
  assign run_last_o    = empty_q || (remain_q == CNT_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      remain_q    <= '0;
      step_q      <= '0;
      have_prev_q <= 1'b0;
      last_q      <= 1'b0;
      sortx_q     <= 1'b0;
      empty_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_beat) begin
        have_prev_q <= 1'b1;
        last_q      <= vertex_last_i;
      end
      count_q <= count_nx;
      if (finish) begin
        // freeze the sort axis, then align the hits to the bottom of the chain
        have_prev_q <= 1'b0;
        sortx_q     <= sortx_c;
        empty_q     <= (count_nx == '0);
        step_q      <= CNT_W'(HIT_CAP) - count_nx;
      end
      if (state_q == S_ALIGN) begin
        step_q <= (step_q == '0) ? CNT_W'(HIT_CAP - 1) : step_q - CNT_W'(1);
      end
      if (state_q == S_SORT) begin
        step_q <= step_q - CNT_W'(1);
        if (step_q == '0) remain_q <= count_q;
      end
      if (out_beat) begin
        remain_q <= remain_q - CNT_W'(1);
        if (run_last_o) begin
          count_q <= '0;
          empty_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      prev_x_q <= vertex_x_i;
      prev_y_q <= vertex_y_i;
    end
  end

  // chain of cells: new hits enter at the top, results leave from cell 0
  for (genvar k = 0; k < HIT_CAP; k++) begin : g_chain
    logic signed [COORD_W-1:0] up_x, up_y, dn_x, dn_y;
    logic                      swap_dn;
    if (k == HIT_CAP - 1) begin : g_top
      assign up_x = hit.x;
      assign up_y = hit.y;
    end else begin : g_mid
      assign up_x = chain_x[k+1];
      assign up_y = chain_y[k+1];
    end
    if (k == 0) begin : g_bot
      assign dn_x    = '0;
      assign dn_y    = '0;
      assign swap_dn = 1'b0;
    end else begin : g_low
      assign dn_x    = chain_x[k-1];
      assign dn_y    = chain_y[k-1];
      assign swap_dn = swap[k-1];
    end
    plc_cell u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (cctrl),
      .idx_i     (CNT_W'(k)),
      .up_x_i    (up_x),
      .up_y_i    (up_y),
      .dn_x_i    (dn_x),
      .dn_y_i    (dn_y),
      .swap_dn_i (swap_dn),
      .x_o       (chain_x[k]),
      .y_o       (chain_y[k]),
      .swap_o    (swap[k])
    );
  end

  // an empty answer is always the single, final beat of its run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !cross_valid_o |-> run_last_o && (cross_count_o == '0))
    else $error("empty result malformed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && cross_valid_o |-> (cross_count_o != '0))
    else $error("crossing beat with zero count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o)
    else $error("input taken while results pending");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat && !run_last_o |=> out_valid_o && cross_valid_o)
    else $error("run cut short");

endmodule
`default_nettype wire

@@ tb/sv/polyline_line_crossings_sorted_tb.sv @@
// Testbench for the polyline crossing finder: random and directed polylines, scoreboarded.
`timescale 1ns / 100ps
`default_nettype none
module polyline_line_crossings_sorted_tb;
  import plc_pkg::*;

  typedef logic signed [255:0] wide_t;
  typedef logic signed [COORD_W-1:0] coord_t;

  // One result beat as the block presents it
  typedef struct {
    coord_t           x;
    coord_t           y;
    logic             valid;
    logic [CNT_W-1:0] count;
    logic             last;
  } crossing_t;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE      = 450;
  localparam int RANDOM_BEATS = 230;
  localparam coord_t ONE = coord_t'(1) << FRAC_W;

  // Shadow of the block: registers, open polyline and the crossings found so far
  class crossing_board;
    plc_cfg_t  cfg;
    coord_t    last_x, last_y;
    bit        open_run;
    coord_t    hit_x[$], hit_y[$];
    crossing_t awaited[$];
    int        errors;

    function new();
      cfg.sx = '0; cfg.sy = '0; cfg.ex = LINE_END_X_RST; cfg.ey = '0;
      cfg.tol = TOL_RST; cfg.plim = PLIM_RST;
      open_run = 0; errors = 0;
    endfunction

    function void set_reg(plc_reg_e idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        REG_LINE_START_X:   cfg.sx = d;
        REG_LINE_START_Y:   cfg.sy = d;
        REG_LINE_END_X:     cfg.ex = d;
        REG_LINE_END_Y:     cfg.ey = d;
        REG_EDGE_TOLERANCE: cfg.tol = d[TOL_W-1:0];
        REG_PARALLEL_LIMIT: cfg.plim = d[PLIM_W-1:0];
        default: ;
      endcase
    endfunction

    static function wide_t mag(wide_t v);
      return (v < 0) ? -v : v;
    endfunction

    static function coord_t clamp(wide_t v);
      wide_t hi, lo;
      hi = COORD_MAX; lo = COORD_MIN;
      if (v > hi) return COORD_MAX;
      if (v < lo) return COORD_MIN;
      return v[COORD_W-1:0];
    endfunction

    // Cut edge (x1,y1)->(x2,y2) with the line; true when the crossing is kept
    function bit cut_edge(coord_t x1c, coord_t y1c, coord_t x2c, coord_t y2c,
                          output coord_t hx, output coord_t hy);
      wide_t sx, sy, a, b, x1, y1, x2, y2, v1, v2, d, tol, lim, cx, cy;
      wide_t mnx, mxx, mny, mxy;
      bit xin, yin, xnear, ynear;
      sx = cfg.sx; sy = cfg.sy;
      a = wide_t'(cfg.ey) - sy;
      b = sx - wide_t'(cfg.ex);
      x1 = x1c; y1 = y1c; x2 = x2c; y2 = y2c;
      tol = '0; tol[TOL_W-1:0] = cfg.tol;
      lim = '0; lim[PLIM_W-1:0] = cfg.plim;
      v1 = a * (x1 - sx) + b * (y1 - sy);
      v2 = a * (x2 - sx) + b * (y2 - sy);
      d = v1 - v2;
      hx = '0; hy = '0;
      if (d == 0 || mag(d) < lim) return 0;
      cx = x1 + ((x2 - x1) * v1) / d;
      cy = y1 + ((y2 - y1) * v1) / d;
      mnx = (x1 <= x2) ? x1 : x2; mxx = (x1 <= x2) ? x2 : x1;
      mny = (y1 <= y2) ? y1 : y2; mxy = (y1 <= y2) ? y2 : y1;
      xin = cx >= mnx && cx <= mxx;
      yin = cy >= mny && cy <= mxy;
      xnear = mag(cx - mnx) < tol || mag(cx - mxx) < tol;
      ynear = mag(cy - mny) < tol || mag(cy - mxy) < tol;
      if (!((xin && yin) || (yin && xnear) || (xin && ynear))) return 0;
      hx = clamp(cx); hy = clamp(cy);
      return 1;
    endfunction

    // Note an accepted vertex beat and queue whatever results it causes
    function void note_vertex(coord_t vx, coord_t vy, logic last);
      coord_t hx, hy, kx, ky;
      crossing_t c;
      bit by_x;
      int n, j;
      wide_t dx, dy;
      if (open_run && cut_edge(last_x, last_y, vx, vy, hx, hy) && hit_x.size() < HIT_CAP) begin
        hit_x = {hit_x, hx}; hit_y = {hit_y, hy};
      end
      last_x = vx; last_y = vy; open_run = 1;
      if (!last) return;
      dx = wide_t'(cfg.ex) - wide_t'(cfg.sx);
      dy = wide_t'(cfg.ey) - wide_t'(cfg.sy);
      by_x = mag(dx) > mag(dy);
      n = hit_x.size();
      // stable insertion sort on the chosen axis
      for (int i = 1; i < n; i++) begin
        kx = hit_x[i]; ky = hit_y[i];
        j = i;
        while (j > 0 && (by_x ? hit_x[j-1] > kx : hit_y[j-1] > ky)) begin
          hit_x[j] = hit_x[j-1]; hit_y[j] = hit_y[j-1];
          j--;
        end
        hit_x[j] = kx; hit_y[j] = ky;
      end
      if (n == 0) begin
        c.x = '0; c.y = '0; c.valid = 0; c.count = '0; c.last = 1;
        awaited = {awaited, c};
      end
      for (int i = 0; i < n; i++) begin
        c.x = hit_x[i]; c.y = hit_y[i]; c.valid = 1;
        c.count = CNT_W'(n); c.last = (i == n - 1);
        awaited = {awaited, c};
      end
      hit_x.delete(); hit_y.delete();
      open_run = 0;
    endfunction

    function void check_crossing(crossing_t got);
      crossing_t w;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected crossing beat: x=%0d y=%0d valid=%0b count=%0d last=%0b",
                   got.x, got.y, got.valid, got.count, got.last);
        return;
      end
      w = awaited.pop_front();
      if (got.x !== w.x || got.y !== w.y || got.valid !== w.valid ||
          got.count !== w.count || got.last !== w.last) begin
        errors++;
        if (errors <= 10)
          $display({"crossing mismatch: exp x=%0d y=%0d v=%0b n=%0d l=%0b, ",
                    "got x=%0d y=%0d v=%0b n=%0d l=%0b"},
                   w.x, w.y, w.valid, w.count, w.last,
                   got.x, got.y, got.valid, got.count, got.last);
      end
    endfunction
  endclass

  logic                  clk_i, rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i, in_ready_o;
  coord_t                vertex_x_i, vertex_y_i;
  logic                  vertex_last_i;
  logic                  out_valid_o, out_ready_i;
  coord_t                cross_x_o, cross_y_o;
  logic                  cross_valid_o;
  logic [CNT_W-1:0]      cross_count_o;
  logic                  run_last_o;

  crossing_board board = new();
  bit quiet;        // phase with no idling on either side
  int sink_hold;
  int cycles;
  int vertices_sent;

  polyline_line_crossings_sorted dut (.*);

  // 100 MHz clock
  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  // Watchdog: end the run if the block stops making progress
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Result side: check each beat, then draw how long to hold ready low before the next
  always @(posedge clk_i) begin
    crossing_t got;
    int hold;
    hold = sink_hold;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.x = cross_x_o; got.y = cross_y_o; got.valid = cross_valid_o;
      got.count = cross_count_o; got.last = run_last_o;
      board.check_crossing(got);
      hold = quiet ? 0 : $urandom_range(0, 12);
    end
    if (hold > 0) begin
      out_ready_i <= 1'b0;
      hold--;
    end else begin
      out_ready_i <= rst_ni;
    end
    sink_hold = hold;
  end

  // Write one register; only called while the block is idle
  task automatic write_reg(plc_reg_e idx, logic [CFG_DATA_W-1:0] d);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= d;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.set_reg(idx, d);
    @(posedge clk_i);
  endtask

  task automatic write_line(coord_t sx, coord_t sy, coord_t ex, coord_t ey);
    write_reg(REG_LINE_START_X, sx);
    write_reg(REG_LINE_START_Y, sy);
    write_reg(REG_LINE_END_X, ex);
    write_reg(REG_LINE_END_Y, ey);
  endtask

  // Drop valid, wait until every queued result has come, then let the block settle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.awaited.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Offer one vertex beat; valid stays high straight into the next beat when no gap is drawn
  task automatic send_vertex(coord_t x, coord_t y, logic last);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1; vertex_x_i <= x; vertex_y_i <= y; vertex_last_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_vertex(x, y, last);
    vertices_sent++;
  endtask

  // Mostly coordinates near the origin so edges straddle the line; some full range and extremes
  function automatic coord_t pick_coord();
    case ($urandom_range(0, 9))
      0: return coord_t'({$urandom, $urandom});
      1: case ($urandom_range(0, 3))
           0: return COORD_MAX;
           1: return COORD_MIN;
           2: return '0;
           default: return coord_t'(-1);
         endcase
      default: return coord_t'(longint'($urandom_range(0, 8388608)) - 4194304);
    endcase
  endfunction

  function automatic coord_t pick_small();
    return coord_t'(longint'($urandom_range(0, 4194304)) - 2097152);
  endfunction

  task automatic send_run(int len);
    for (int i = 0; i < len; i++)
      send_vertex(pick_coord(), pick_coord(), i == len - 1);
  endtask

  // Zigzag across the horizontal axis; crossings come in descending x
  task automatic send_zigzag(int len);
    for (int i = 0; i < len; i++)
      send_vertex(coord_t'(len - i) * ONE, (i % 2) ? -ONE : ONE, i == len - 1);
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0; cfg_idx_i = '0; cfg_data_i = '0;
    in_valid_i = 1'b0; vertex_x_i = '0; vertex_y_i = '0; vertex_last_i = 1'b0;
    out_ready_i = 1'b0;
    cycles = 0; sink_hold = 0; vertices_sent = 0; quiet = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part with the reset line (the x axis)
    send_vertex(ONE, ONE, 1'b1);                   // lone vertex: empty answer
    send_zigzag(4);                                // sorting reverses edge order
    send_vertex('0, ONE, 1'b0);                    // edge parallel to the line
    send_vertex(5 * ONE, ONE, 1'b1);
    send_vertex(COORD_MAX, COORD_MAX, 1'b0);       // corner to corner
    send_vertex(COORD_MIN, COORD_MIN, 1'b1);
    send_vertex(COORD_MIN, COORD_MAX, 1'b0);
    send_vertex(COORD_MAX, COORD_MIN, 1'b1);
    send_vertex(ONE, '0, 1'b0);                    // crossing on an end point
    send_vertex(2 * ONE, ONE, 1'b0);
    send_vertex(3 * ONE, -ONE, 1'b1);
    drain();

    // Near-vertical line: sort by y, zero slack and no parallel limit
    write_line(ONE, -ONE, ONE + 3, 4 * ONE);
    write_reg(REG_EDGE_TOLERANCE, '0);
    write_reg(REG_PARALLEL_LIMIT, '0);
    send_vertex('0, 3 * ONE, 1'b0);
    send_vertex(2 * ONE, 2 * ONE, 1'b0);
    send_vertex('0, ONE, 1'b0);
    send_vertex(2 * ONE, -ONE, 1'b1);
    drain();

    // Widest slack and parallel limit; then a degenerate line
    write_reg(REG_EDGE_TOLERANCE, CFG_DATA_W'(16'hFFFF));
    write_reg(REG_PARALLEL_LIMIT, CFG_DATA_W'(32'hFFFF_FFFF));
    send_run(4);
    drain();
    write_line(ONE, ONE, ONE, ONE);
    send_run(3);
    drain();

    // Full store: more crossings than the block keeps
    write_line('0, '0, ONE, '0);
    write_reg(REG_PARALLEL_LIMIT, CFG_DATA_W'(PLIM_RST));
    quiet = 1;
    send_zigzag(34);
    drain();
    quiet = 0;

    // Random phases: new settings, then a few polylines each
    while (vertices_sent < RANDOM_BEATS) begin
      case ($urandom_range(0, 4))
        0: write_line(coord_t'({$urandom, $urandom}), coord_t'({$urandom, $urandom}),
                      coord_t'({$urandom, $urandom}), coord_t'({$urandom, $urandom}));
        1: write_line(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN);
        default: write_line(pick_small(), pick_small(), pick_small(), pick_small());
      endcase
      write_reg(REG_EDGE_TOLERANCE,
                CFG_DATA_W'($urandom_range(0, 3) == 0 ? 16'hFFFF : $urandom_range(0, 300)));
      write_reg(REG_PARALLEL_LIMIT,
                CFG_DATA_W'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 600000)));
      quiet = ($urandom_range(0, 4) == 0);
      repeat ($urandom_range(2, 5)) send_run($urandom_range(1, 9));
      drain();
    end
    drain();

    if (board.errors == 0 && board.awaited.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
`default_nettype wire

@@ polyline_line_crossings_sorted.f @@
hdl/plc_pkg.sv
hdl/plc_edge.sv
hdl/plc_cell.sv
hdl/polyline_line_crossings_sorted.sv
tb/sv/polyline_line_crossings_sorted_tb.sv
